/* rtl/fsdc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsdc_pkg
// Shared types, constants and helpers of the single/double format converter.
// ----------------------------------------------------------------------------
package fsdc_pkg;

   localparam logic [7:0]  S_EXP_ALL  = 8'hFF;
   localparam logic [10:0] D_EXP_ALL  = 11'h7FF;
   localparam logic [10:0] D_REBIAS   = 11'd896;   // 1023 - 127
   localparam logic [10:0] D_HUGE     = 11'd1150;  // 1023 + 127
   localparam logic [10:0] D_TINY     = 11'd873;   // 1023 - 150
   localparam logic [10:0] D_EMIN     = 11'd897;   // 1023 - 126

   localparam logic CMD_S2D = 1'b0;
   localparam logic CMD_D2S = 1'b1;

   typedef struct packed {
      logic        cmd;
      logic        sign;
      logic        rnd;     // round from guard bit
      logic        shl;     // shift left, else right
      logic [4:0]  shamt;
      logic [24:0] mant;
      logic [10:0] expo;
   } dec_type;

   // Leading zeros of a 23-bit fraction (input non-zero).
   function automatic logic [4:0] lzc23(input logic [22:0] f);
      logic [4:0] n;
      n = 5'd0;
      for (int i = 0; i < 23; i++) begin
         if (f[i]) begin
            n = 5'(22 - i);
         end
      end
      return n;
   endfunction

endpackage

/* rtl/fsdc_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsdc_req_if / fsdc_rsp_if
// Valid/ready channels for operands and converted results.
// ----------------------------------------------------------------------------
interface fsdc_req_if;
   logic        valid;
   logic        ready;
   logic        cmd;
   logic [63:0] operand;
   modport source (output valid, cmd, operand, input ready);
   modport sink   (input valid, cmd, operand, output ready);
endinterface

interface fsdc_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] converted;
   modport source (output valid, converted, input ready);
   modport sink   (input valid, converted, output ready);
endinterface

/* rtl/fsdc_decode.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsdc_decode
// Stage 1: classify the operand, pick exponent and shift.
// ----------------------------------------------------------------------------
module fsdc_decode
   import fsdc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   input  logic        cmd,
   input  logic [63:0] operand,
   output logic        out_valid,
   input  logic        out_ready,
   output dec_type     out_data
);

   logic    valid_ff;
   dec_type data_ff, data_in;
   logic [7:0]  se;
   logic [22:0] sf;
   logic [10:0] de;
   logic [4:0]  lz;
   logic [10:0] dshift;

   assign se     = operand[30:23];
   assign sf     = operand[22:0];
   assign de     = operand[62:52];
   assign lz     = lzc23(sf);
   assign dshift = D_EMIN - de;

   always_comb begin
      data_in       = '0;
      data_in.cmd   = cmd;
      if (cmd == CMD_S2D) begin
         data_in.sign = operand[31];
         data_in.mant = {2'b00, sf};
         if (se == S_EXP_ALL) begin
            data_in.expo = D_EXP_ALL;
         end else if (se == 8'd0) begin
            if (sf != 23'd0) begin
               data_in.shl   = 1'b1;
               data_in.shamt = lz + 5'd1;
               data_in.expo  = D_REBIAS - {6'd0, lz};
            end
         end else begin
            data_in.expo = {3'd0, se} + D_REBIAS;
         end
      end else begin
         data_in.sign = operand[63];
         if (de == D_EXP_ALL) begin
            data_in.expo = {3'd0, S_EXP_ALL};
            data_in.mant = {2'b00, operand[51:29]};
         end else if (de > D_HUGE) begin
            data_in.expo = {3'd0, S_EXP_ALL};
         end else if (de < D_TINY) begin
            data_in.expo = '0;
         end else if (de < D_EMIN) begin
            data_in.rnd   = 1'b1;
            data_in.mant  = {1'b1, operand[51:28]};
            data_in.shamt = dshift[4:0];
         end else begin
            data_in.rnd  = 1'b1;
            data_in.mant = {1'b0, operand[51:28]};
            data_in.expo = de - D_REBIAS;
         end
      end
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

/* rtl/fsdc_align.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsdc_align
// Stage 2: normalising left shift or denormal right shift.
// ----------------------------------------------------------------------------
module fsdc_align
   import fsdc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  dec_type in_data,
   output logic    out_valid,
   input  logic    out_ready,
   output dec_type out_data
);

   logic    valid_ff;
   dec_type data_ff, data_in;

   always_comb begin
      data_in = in_data;
      if (in_data.shl) begin
         data_in.mant = in_data.mant << in_data.shamt;
      end else begin
         data_in.mant = in_data.mant >> in_data.shamt;
      end
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

/* rtl/fsdc_round.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsdc_round
// Stage 3: guard-bit rounding, exponent carry and packing.
// ----------------------------------------------------------------------------
module fsdc_round
   import fsdc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   input  dec_type     in_data,
   output logic        out_valid,
   input  logic        out_ready,
   output logic [63:0] out_data
);

   logic        valid_ff;
   logic        cmd_ff;
   logic [63:0] data_ff, data_in;
   logic [24:0] sum;
   logic        carry;
   logic [22:0] frac;
   logic [7:0]  e8;

   assign sum   = {1'b0, in_data.mant[23:0]} + 25'd1;
   assign carry = in_data.rnd && sum[24];
   assign e8    = in_data.expo[7:0] + {7'd0, carry};

   always_comb begin
      if (!in_data.rnd) begin
         frac = in_data.mant[22:0];
      end else if (carry) begin
         frac = '0;
      end else begin
         frac = sum[23:1];
      end
      if (in_data.cmd == CMD_S2D) begin
         data_in = {in_data.sign, in_data.expo, frac, 29'd0};
      end else begin
         data_in = {32'd0, in_data.sign, e8, frac};
      end
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         data_ff <= data_in;
         cmd_ff  <= in_data.cmd;
      end
   end

   a_single_upper_zero : assert property (@(posedge clock) disable iff (reset)
      valid_ff && cmd_ff == CMD_D2S |-> data_ff[63:32] == 32'd0)
      else $error("single result with upper bits set");

   a_stall_keeps : assert property (@(posedge clock) disable iff (reset)
      valid_ff && !out_ready |=> valid_ff && $stable(data_ff))
      else $error("stalled result lost");

   a_reset_empty : assert property (@(posedge clock)
      $past(reset) |-> !valid_ff)
      else $error("result valid after reset");

endmodule

/* rtl/fp_single_double_convert_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fp_single_double_convert_core
// IEEE 754 single <-> double conversion, three-stage pipeline.
//
//   channel  dir  payload
//   req      in   cmd, operand[63:0]
//   rsp      out  converted[63:0]
//
// Registered stages decode, align shift and round; one transaction per cycle
// sustained while rsp accepts. Synchronous active-high reset empties the
// pipeline. Each stage holds its transaction while the next one stalls; a
// stall at rsp backs up stage by stage to req.ready.
// ----------------------------------------------------------------------------
module fp_single_double_convert_core
   import fsdc_pkg::*;
(
   input logic       clock,
   input logic       reset,
   fsdc_req_if.sink  req_chan,
   fsdc_rsp_if.source rsp_chan
);

   logic    v1, r1, v2, r2;
   dec_type d1, d2;

   fsdc_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_chan.valid),
      .in_ready  (req_chan.ready),
      .cmd       (req_chan.cmd),
      .operand   (req_chan.operand),
      .out_valid (v1),
      .out_ready (r1),
      .out_data  (d1)
   );

   fsdc_align u_align (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v1),
      .in_ready  (r1),
      .in_data   (d1),
      .out_valid (v2),
      .out_ready (r2),
      .out_data  (d2)
   );

   fsdc_round u_round (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v2),
      .in_ready  (r2),
      .in_data   (d2),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .out_data  (rsp_chan.converted)
   );

endmodule
